// ===== rtl/wkbpx_pkg.sv =====
package wkbpx_pkg;

  localparam int NEST_DEPTH_DEF = 8;
  localparam int OUT_DEPTH = 4;

  localparam logic [7:0] MAGIC_G = 8'h47;
  localparam logic [7:0] MAGIC_P = 8'h50;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_ORDER,
    PH_TYPE,
    PH_LINE_COUNT,
    PH_RING_TOTAL,
    PH_MEMBER_COUNT,
    PH_RING_POINTS,
    PH_COORD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        line_start;
    logic [31:0] points_parsed;
    logic        last;
  } res_t;

  // Header length contributed by the envelope code in the flags byte.
  function automatic logic [6:0] envelope_bytes(input logic [7:0] flags);
    case (flags[3:1])
      3'd1:       envelope_bytes = 7'd32;
      3'd2, 3'd3: envelope_bytes = 7'd48;
      3'd4:       envelope_bytes = 7'd64;
      default:    envelope_bytes = 7'd0;
    endcase
  endfunction

endpackage

// ===== rtl/wkb_geometry_point_extractor_top.sv =====
// GeoPackage geometry blob point extractor.
//
// Blob bytes arrive on the slave stream, one byte per beat in s_tdata with
// s_tlast on the final byte of each blob. Every accepted byte is parsed in
// the cycle it is taken; a new byte can be accepted every cycle if the queue has room.
// Results leave on the master stream: point beats (m_tuser = point) carry
// the raw x and y doubles, and each blob ends with one status beat
// (accepted or rejected) holding the saturating point count. m_tlast marks
// the final result caused by one input byte. A rejected blob may already
// have produced point beats, which the receiver must discard.
// The results of an accepted byte are registered into the output queue.
// Results pass through a four-entry output queue; a byte is taken only while
// at least two entries are free, so a stalled receiver holds off the input
// once three or four results are waiting, and nothing is lost.
// The single configuration register (geometry mode: 0 lines, 1 polygons) is
// written through cfg_valid/cfg_data, always ready, and should change only
// while the block is idle.
// Synchronous reset empties the queue, clears the parser to expect a header
// and sets line mode. The nesting stack holds NEST_DEPTH containers.
module wkb_geometry_point_extractor_top #(
  parameter int NEST_DEPTH = wkbpx_pkg::NEST_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // end_of_blob
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // x_bits, y_bits, line_start, points_parsed, zero fill
  output logic [1:0]   m_tuser,   // result_kind
  output logic         m_tlast,   // last_result
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data   // geometry_mode
);
  import wkbpx_pkg::*;

  logic mode;
  logic take;
  logic room;
  logic pt_valid, st_valid;
  res_t pt_res, st_res, q_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= cfg_data[0];
    end
  end

  assign s_tready = room;
  assign take     = s_tvalid && room;

  wkbpx_parser #(.NEST_DEPTH(NEST_DEPTH)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .mode     (mode),
    .pt_valid (pt_valid),
    .st_valid (st_valid),
    .pt_res   (pt_res),
    .st_res   (st_res)
  );

  // A point, when present, goes ahead of the status beat of the same byte.
  wkbpx_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_a     (take && (pt_valid || st_valid)),
    .data_a   (pt_valid ? pt_res : st_res),
    .wr_b     (take && pt_valid && st_valid),
    .data_b   (st_res),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (q_res)
  );

  assign m_tdata = {7'd0, q_res.points_parsed, q_res.line_start,
                    q_res.y_bits, q_res.x_bits};
  assign m_tuser = q_res.kind;
  assign m_tlast = q_res.last;

endmodule

// ===== rtl/wkbpx_parser.sv =====
module wkbpx_parser #(
  parameter int NEST_DEPTH = wkbpx_pkg::NEST_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic            mode,
  output logic            pt_valid,
  output logic            st_valid,
  output wkbpx_pkg::res_t pt_res,
  output wkbpx_pkg::res_t st_res
);
  import wkbpx_pkg::*;

  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  phase_t      phase, phase_next;
  logic [6:0]  hdr_pos, hdr_pos_next, hdr_len, hdr_len_next;
  logic [63:0] asm_val, asm_next;
  logic [3:0]  idx, idx_next;
  logic        little, little_next;
  logic [2:0]  ccount, ccount_next;
  logic [1:0]  cidx, cidx_next;
  logic [63:0] held_x, held_x_next;
  logic [31:0] stack [NEST_DEPTH];
  logic [NEST_DEPTH-1:0] nz;
  logic [LW-1:0] level, level_next;
  logic [31:0] pts_rem, pts_rem_next;
  logic        emit, emit_next, first, first_next, ring, ring_next;
  logic [31:0] total, total_next;

  // gathered field
  logic [63:0] g_val;
  logic [3:0]  idx_inc;
  logic [31:0] t32;
  logic [31:0] base;
  logic [2:0]  dims;

  // stack control
  logic          want_finish, want_push, push_rings;
  logic [31:0]   push_count;
  logic          fin_found;
  logic [IW-1:0] fin_t;
  logic          stk_we;
  logic [IW-1:0] stk_wa;
  logic [31:0]   stk_wd;
  logic [2:0]    cidx_inc;

  always_comb begin
    if (little) begin
      g_val = asm_val | ({56'd0, in_byte} << {idx[2:0], 3'b000});
    end else begin
      g_val = {asm_val[55:0], in_byte};
    end
    idx_inc = idx + 4'd1;
    t32 = g_val[31:0];
  end

  always_comb begin
    if (t32[31:29] != 3'd0) begin
      base = {24'd0, t32[7:0]};
      dims = 3'd2 + {2'd0, t32[31]} + {2'd0, t32[30]};
    end else if (t32 >= 32'd3000 && t32 < 32'd4000) begin
      base = t32 - 32'd3000;
      dims = 3'd4;
    end else if (t32 >= 32'd2000 && t32 < 32'd3000) begin
      base = t32 - 32'd2000;
      dims = 3'd3;
    end else if (t32 >= 32'd1000 && t32 < 32'd2000) begin
      base = t32 - 32'd1000;
      dims = 3'd3;
    end else begin
      base = t32;
      dims = 3'd2;
    end
  end

  // Deepest open container that still has siblings to come.
  always_comb begin
    fin_found = 1'b0;
    fin_t = '0;
    for (int i = 0; i < NEST_DEPTH; i++) begin
      if (LW'(i) < level && nz[i]) begin
        fin_found = 1'b1;
        fin_t = IW'(i);
      end
    end
  end

  always_comb begin
    phase_next   = phase;
    hdr_pos_next = hdr_pos;
    hdr_len_next = hdr_len;
    asm_next     = asm_val;
    idx_next     = idx;
    little_next  = little;
    ccount_next  = ccount;
    cidx_next    = cidx;
    held_x_next  = held_x;
    level_next   = level;
    pts_rem_next = pts_rem;
    emit_next    = emit;
    first_next   = first;
    ring_next    = ring;
    total_next   = total;
    want_finish  = 1'b0;
    want_push    = 1'b0;
    push_count   = 32'd0;
    push_rings   = 1'b0;
    stk_we       = 1'b0;
    stk_wa       = '0;
    stk_wd       = 32'd0;
    pt_valid     = 1'b0;
    cidx_inc     = 3'd0;
    pt_res       = '0;

    case (phase)
      PH_HEADER: begin
        if ((hdr_pos == 7'd0 && in_byte != MAGIC_G) ||
            (hdr_pos == 7'd1 && in_byte != MAGIC_P)) begin
          phase_next = PH_ERROR;
        end else begin
          if (hdr_pos == 7'd3) begin
            hdr_len_next = 7'd8 + envelope_bytes(in_byte);
          end
          hdr_pos_next = hdr_pos + 7'd1;
          if (hdr_pos_next >= hdr_len_next) begin
            phase_next = PH_ORDER;
          end
        end
      end
      PH_ORDER: begin
        if (in_byte > 8'd1) begin
          phase_next = PH_ERROR;
        end else begin
          little_next = in_byte[0];
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE, PH_LINE_COUNT, PH_RING_TOTAL, PH_MEMBER_COUNT, PH_RING_POINTS: begin
        asm_next = g_val;
        idx_next = idx_inc;
        if (idx_inc >= 4'd4) begin
          asm_next = 64'd0;
          idx_next = 4'd0;
          case (phase)
            PH_TYPE: begin
              ccount_next = dims;
              if (!mode) begin
                if (base == 32'd2) phase_next = PH_LINE_COUNT;
                else if (base == 32'd5 || base == 32'd7) phase_next = PH_MEMBER_COUNT;
                else phase_next = PH_ERROR;
              end else begin
                if (base == 32'd3) phase_next = PH_RING_TOTAL;
                else if (base == 32'd6 || base == 32'd7) phase_next = PH_MEMBER_COUNT;
                else phase_next = PH_ERROR;
              end
            end
            PH_LINE_COUNT: begin
              emit_next = (t32 >= 32'd2);
              first_next = 1'b1;
              pts_rem_next = t32;
              cidx_next = 2'd0;
              if (t32 == 32'd0) want_finish = 1'b1;
              else phase_next = PH_COORD;
            end
            PH_RING_TOTAL: begin
              emit_next = 1'b1;
              first_next = 1'b1;
              if (t32 == 32'd0) want_finish = 1'b1;
              else begin
                want_push = 1'b1;
                push_count = t32;
                push_rings = 1'b1;
              end
            end
            PH_MEMBER_COUNT: begin
              if (t32 == 32'd0) want_finish = 1'b1;
              else begin
                want_push = 1'b1;
                push_count = t32;
              end
            end
            default: begin
              pts_rem_next = t32;
              cidx_next = 2'd0;
              if (t32 == 32'd0) want_finish = 1'b1;
              else phase_next = PH_COORD;
            end
          endcase
        end
      end
      PH_COORD: begin
        asm_next = g_val;
        idx_next = idx_inc;
        if (idx_inc >= 4'd8) begin
          asm_next = 64'd0;
          idx_next = 4'd0;
          if (cidx == 2'd0) begin
            held_x_next = g_val;
          end else if (cidx == 2'd1) begin
            if (total != 32'hFFFF_FFFF) total_next = total + 32'd1;
            if (emit) begin
              pt_valid = 1'b1;
              pt_res.kind = KIND_POINT;
              pt_res.x_bits = held_x;
              pt_res.y_bits = g_val;
              pt_res.line_start = first;
              pt_res.last = !in_end;
            end
            first_next = 1'b0;
          end
          cidx_inc = {1'b0, cidx} + 3'd1;
          cidx_next = cidx_inc[1:0];
          if ({1'b0, cidx_next} >= ccount || cidx_next == 2'd0) begin
            cidx_next = 2'd0;
            pts_rem_next = pts_rem - 32'd1;
            if (pts_rem == 32'd1) want_finish = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (want_push) begin
      if (level >= LW'(NEST_DEPTH)) begin
        phase_next = PH_ERROR;
      end else begin
        stk_we = 1'b1;
        stk_wa = IW'(level);
        stk_wd = push_count - 32'd1;
        level_next = level + LW'(1);
        ring_next = push_rings;
        phase_next = push_rings ? PH_RING_POINTS : PH_ORDER;
      end
    end

    if (want_finish) begin
      if (fin_found) begin
        stk_we = 1'b1;
        stk_wa = fin_t;
        stk_wd = stack[fin_t] - 32'd1;
        level_next = LW'(fin_t) + LW'(1);
        ring_next = (LW'(fin_t) == level - LW'(1)) ? ring : 1'b0;
        phase_next = ring_next ? PH_RING_POINTS : PH_ORDER;
      end else begin
        level_next = '0;
        ring_next = 1'b0;
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin
    st_valid = in_end;
    st_res = '0;
    st_res.kind = (phase_next == PH_DONE) ? KIND_ACCEPTED : KIND_REJECTED;
    st_res.points_parsed = total_next;
    st_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take && stk_we) begin
      stack[stk_wa] <= stk_wd;
      nz[stk_wa] <= (stk_wd != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_end)) begin
      phase   <= PH_HEADER;
      hdr_pos <= 7'd0;
      hdr_len <= 7'd8;
      asm_val <= 64'd0;
      idx     <= 4'd0;
      little  <= 1'b1;
      ccount  <= 3'd2;
      cidx    <= 2'd0;
      held_x  <= 64'd0;
      level   <= '0;
      pts_rem <= 32'd0;
      emit    <= 1'b0;
      first   <= 1'b0;
      ring    <= 1'b0;
      total   <= 32'd0;
    end else if (take) begin
      phase   <= phase_next;
      hdr_pos <= hdr_pos_next;
      hdr_len <= hdr_len_next;
      asm_val <= asm_next;
      idx     <= idx_next;
      little  <= little_next;
      ccount  <= ccount_next;
      cidx    <= cidx_next;
      held_x  <= held_x_next;
      level   <= level_next;
      pts_rem <= pts_rem_next;
      emit    <= emit_next;
      first   <= first_next;
      ring    <= ring_next;
      total   <= total_next;
    end
  end

endmodule

// ===== rtl/wkbpx_out_fifo.sv =====
module wkbpx_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_a,
  input  wkbpx_pkg::res_t data_a,
  input  logic            wr_b,
  input  wkbpx_pkg::res_t data_b,
  output logic            room,
  output logic            rd_valid,
  input  logic            rd_ready,
  output wkbpx_pkg::res_t rd_data
);
  import wkbpx_pkg::*;

  localparam int AW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  res_t          mem [OUT_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          pop;
  logic [AW-1:0] wp_b;
  logic [CW-1:0] n_wr;

  assign room     = (cnt <= CW'(OUT_DEPTH - 2));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign pop      = rd_valid && rd_ready;
  assign wp_b     = wr_a ? wp + AW'(1) : wp;
  assign n_wr     = CW'(wr_a) + CW'(wr_b);

  always_ff @(posedge clk) begin
    if (wr_a) mem[wp] <= data_a;
    if (wr_b) mem[wp_b] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + AW'(n_wr);
      if (pop) rp <= rp + AW'(1);
      cnt <= cnt + n_wr - CW'(pop);
    end
  end

endmodule

// ===== tb/sv/tb_wkb_geometry_point_extractor_top.sv =====
`timescale 1ns / 1ps

// Blob parser bench. Blobs of GeoPackage geometry are built at random, mostly
// well formed with nested containers, mixed byte orders and the various type
// code encodings, and partly broken on purpose. A clocked driver feeds them byte
// by byte; a clocked monitor compares every result beat with the prediction.
module tb_wkb_geometry_point_extractor_top;
  import wkbpx_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DEPTH = 8;

  // Geometry type codes of well-known binary.
  localparam logic [31:0] GT_POINT = 32'd1;
  localparam logic [31:0] GT_LINE = 32'd2;
  localparam logic [31:0] GT_POLY = 32'd3;
  localparam logic [31:0] GT_MLINE = 32'd5;
  localparam logic [31:0] GT_MPOLY = 32'd6;
  localparam logic [31:0] GT_COLL = 32'd7;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } blob_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_data = '0;

  wkb_geometry_point_extractor_top u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #4 clk = ~clk;

  blob_byte_t pending_bytes[$];
  res_t       expected_results[$];
  int         errors = 0;
  int         cycle = 0;
  int         bytes_in = 0;
  int         n_points = 0;
  int         n_accepted = 0;
  int         n_rejected = 0;
  int         cfg_writes = 0;
  bit         cfg_req = 0;
  logic       cfg_want = 0;
  int         hold_left = 0;
  bit         hold_done = 0;
  blob_byte_t next_byte;

  // The calm window lets both streams run with no idling at all.
  wire idle_ok = !(cycle >= 1000 && cycle < 1600);

  // ---------------------------------------------------------------------------
  // Parser predictor. Its state mirrors the block and is cleared per blob.
  // ---------------------------------------------------------------------------
  logic        mode_q;
  phase_t      phase;
  logic [6:0]  hdr_pos, hdr_len;
  logic [63:0] asm_val;
  logic [3:0]  asm_idx;
  logic        order_le;
  logic [2:0]  n_coords;
  logic [1:0]  coord_idx;
  logic [63:0] x_hold;
  logic [31:0] left_stack[DEPTH];
  int          level;
  logic [31:0] pts_left;
  logic        emit_pts, first_pt, rings_on_top;
  logic [31:0] pt_total;

  function automatic int env_size(logic [7:0] flags);
    case (flags[3:1])
      3'd1:       return 32;
      3'd2, 3'd3: return 48;
      3'd4:       return 64;
      default:    return 0;
    endcase
  endfunction

  function void clear_parser();
    phase = PH_HEADER; hdr_pos = 0; hdr_len = 7'd8; asm_val = 0; asm_idx = 0;
    order_le = 1; n_coords = 3'd2; coord_idx = 0; x_hold = 0; level = 0;
    pts_left = 0; emit_pts = 0; first_pt = 0; pt_total = 0; rings_on_top = 0;
  endfunction

  function bit collect(logic [7:0] b, int n, output logic [63:0] v);
    if (order_le) asm_val |= 64'(b) << (8 * asm_idx[2:0]);
    else asm_val = {asm_val[55:0], b};
    asm_idx++;
    v = asm_val;
    if (asm_idx < n) return 0;
    asm_val = 0;
    asm_idx = 0;
    return 1;
  endfunction

  // Current item is complete: move to the next sibling or climb out.
  function void item_done();
    while (level > 0) begin
      if (left_stack[level-1] != 0) begin
        left_stack[level-1]--;
        phase = rings_on_top ? PH_RING_POINTS : PH_ORDER;
        return;
      end
      level--;
      rings_on_top = 0;
    end
    phase = PH_DONE;
  endfunction

  function void open_container(logic [31:0] cnt, logic rings);
    if (level >= DEPTH) begin
      phase = PH_ERROR;
      return;
    end
    left_stack[level] = cnt;
    level++;
    rings_on_top = rings;
    item_done();
  endfunction

  function void type_decoded(logic [31:0] t);
    logic [31:0] base;
    if (t[31:29] != 0) begin
      base = t & 32'hFF;
      n_coords = 3'd2 + t[31] + t[30];
    end else if (t >= 3000 && t < 4000) begin
      base = t - 3000; n_coords = 4;
    end else if (t >= 2000 && t < 3000) begin
      base = t - 2000; n_coords = 3;
    end else if (t >= 1000 && t < 2000) begin
      base = t - 1000; n_coords = 3;
    end else begin
      base = t; n_coords = 2;
    end
    if (!mode_q)
      phase = (base == GT_LINE) ? PH_LINE_COUNT :
              (base == GT_MLINE || base == GT_COLL) ? PH_MEMBER_COUNT : PH_ERROR;
    else
      phase = (base == GT_POLY) ? PH_RING_TOTAL :
              (base == GT_MPOLY || base == GT_COLL) ? PH_MEMBER_COUNT : PH_ERROR;
  endfunction

  function void enter_points(logic [31:0] c);
    pts_left = c;
    coord_idx = 0;
    if (c == 0) item_done();
    else phase = PH_COORD;
  endfunction

  // Advances the predictor by one byte and queues the results it causes.
  function automatic void predict_byte(logic [7:0] b, logic eob);
    logic [63:0] v;
    res_t r;
    bit pt = 0;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if ((hdr_pos == 0 && b != MAGIC_G) || (hdr_pos == 1 && b != MAGIC_P))
          phase = PH_ERROR;
        else begin
          if (hdr_pos == 3) hdr_len = 7'(8 + env_size(b));
          hdr_pos++;
          if (hdr_pos >= hdr_len) phase = PH_ORDER;
        end
      end
      PH_ORDER: begin
        if (b > 1) phase = PH_ERROR;
        else begin
          order_le = b[0];
          phase = PH_TYPE;
        end
      end
      PH_TYPE: if (collect(b, 4, v)) type_decoded(v[31:0]);
      PH_LINE_COUNT: if (collect(b, 4, v)) begin
        emit_pts = (v[31:0] >= 2);
        first_pt = 1;
        enter_points(v[31:0]);
      end
      PH_RING_TOTAL: if (collect(b, 4, v)) begin
        emit_pts = 1;
        first_pt = 1;
        if (v[31:0] == 0) item_done();
        else open_container(v[31:0], 1);
      end
      PH_MEMBER_COUNT: if (collect(b, 4, v)) begin
        if (v[31:0] == 0) item_done();
        else open_container(v[31:0], 0);
      end
      PH_RING_POINTS: if (collect(b, 4, v)) enter_points(v[31:0]);
      PH_COORD: if (collect(b, 8, v)) begin
        if (coord_idx == 0) x_hold = v;
        else if (coord_idx == 1) begin
          if (pt_total != 32'hFFFF_FFFF) pt_total++;
          if (emit_pts) begin
            pt = 1;
            r.kind = KIND_POINT; r.x_bits = x_hold; r.y_bits = v;
            r.line_start = first_pt; r.last = !eob;
          end
          first_pt = 0;
        end
        coord_idx++;
        if (coord_idx >= n_coords || coord_idx == 0) begin
          coord_idx = 0;
          pts_left--;
          if (pts_left == 0) item_done();
        end
      end
      default: ;
    endcase
    if (pt) expected_results.insert(expected_results.size(), r);
    if (eob) begin
      r = '0;
      r.kind = (phase == PH_DONE) ? KIND_ACCEPTED : KIND_REJECTED;
      r.points_parsed = pt_total;
      r.last = 1;
      expected_results.insert(expected_results.size(), r);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Blob construction.
  // ---------------------------------------------------------------------------
  blob_byte_t blob[$];

  function void put(logic [7:0] b);
    blob_byte_t e;
    e.data = b;
    e.last = 0;
    blob.insert(blob.size(), e);
  endfunction

  function void put_word(logic [63:0] v, int n, bit le);
    for (int i = 0; i < n; i++)
      put(le ? v[8*i +: 8] : v[8*(n-1-i) +: 8]);
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Writes a geometry header with a random encoding and returns its
  // coordinate count per point.
  function int put_geom_head(logic [31:0] base, bit le);
    int dims;
    logic [31:0] code;
    case ($urandom_range(3))
      0: begin code = base; dims = 2; end
      1: begin
        dims = $urandom_range(1, 3);
        code = base + 1000 * dims;
        dims = (dims == 3) ? 4 : 3;
      end
      2: begin
        // EWKB flags, the SRID flag among them, over bits 27:8 that are zero or random.
        code = {3'($urandom_range(1, 7)), 29'(base)};
        code[27:8] = $urandom_range(1) ? 20'(0) : 20'($urandom);
        dims = 2 + code[31] + code[30];
      end
      default: begin code = base; dims = 2; end
    endcase
    put({7'd0, le});
    put_word(code, 4, le);
    return dims;
  endfunction

  function int small_count();
    return $urandom_range(9) == 0 ? 0 : $urandom_range(1, 4);
  endfunction

  function void put_points(int cnt, int dims, bit le);
    for (int i = 0; i < cnt * dims; i++) put_word(rand64(), 8, le);
  endfunction

  function automatic void put_geom(bit mode, int depth);
    bit le = $urandom_range(1);
    int pick = $urandom_range(depth > 2 ? 1 : 2);
    int dims, cnt, rings;
    if (pick == 0 && !mode) begin
      dims = put_geom_head(GT_LINE, le);
      cnt = $urandom_range(4) == 0 ? $urandom_range(1) : $urandom_range(2, 4);
      put_word(cnt, 4, le);
      put_points(cnt, dims, le);
    end else if (pick == 0) begin
      dims = put_geom_head(GT_POLY, le);
      rings = $urandom_range(6) == 0 ? 0 : $urandom_range(1, 2);
      put_word(rings, 4, le);
      for (int r = 0; r < rings; r++) begin
        cnt = small_count();
        put_word(cnt, 4, le);
        put_points(cnt, dims, le);
      end
    end else begin
      void'(put_geom_head(pick == 1 ? (mode ? GT_MPOLY : GT_MLINE) : GT_COLL, le));
      cnt = $urandom_range(6) == 0 ? 0 : $urandom_range(1, 3);
      put_word(cnt, 4, le);
      for (int m = 0; m < cnt; m++) put_geom(mode, pick == 1 ? 99 : depth + 1);
    end
  endfunction

  // One blob: a header, a geometry, and now and then a deliberate fault.
  function automatic void queue_blob(bit mode);
    logic [7:0] flags = 8'($urandom);
    int hl = 8 + env_size(flags);
    int fault = $urandom_range(19);
    blob.delete();
    put(MAGIC_G); put(MAGIC_P); put(8'($urandom)); put(flags);
    put_word(rand64(), 4, 1);
    for (int i = 8; i < hl; i++) put(8'($urandom));
    if (fault == 0) begin
      // Collections nested to the stack depth or one level past it.
      for (int i = 0; i < DEPTH + $urandom_range(1); i++) begin
        void'(put_geom_head(GT_COLL, 1));
        put_word(1, 4, 1);
      end
    end
    put_geom(fault == 1 ? !mode : mode, 0);
    case (fault)
      2: blob = blob[0 : $urandom_range(blob.size() - 2)];
      3: blob[$urandom_range(1)].data = 8'($urandom_range(0, 70));
      4: blob[hl].data = 8'($urandom_range(2, 255));
      5, 6: for (int i = $urandom_range(1, 6); i > 0; i--) put(8'($urandom));
      default: ;
    endcase
    blob[blob.size() - 1].last = 1;
    foreach (blob[i]) pending_bytes.insert(pending_bytes.size(), blob[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the accepted byte into the predictor, then offers the next.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("Timeout after %0d cycles", LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata, s_tlast);
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() > 0 && !(idle_ok && $urandom_range(99) < 7)) begin
          next_byte = pending_bytes.pop_front();
          s_tvalid <= 1;
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.last;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Configuration writes are requested by the stimulus and made here.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 0;
      mode_q = 0;
      clear_parser();
    end else if (cfg_valid && cfg_ready) begin
      mode_q = cfg_data[0];
      cfg_valid <= 0;
      cfg_writes++;
    end else if (cfg_req) begin
      cfg_valid <= 1;
      cfg_data <= cfg_want;
      cfg_req = 0;
    end
  end

  // Receiver readiness, with one long hold-off once traffic is under way so
  // that the output queue fills and the input stream is stalled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (!hold_done && bytes_in >= 400) begin
      hold_done = 1;
      hold_left = 300;
      m_tready <= 0;
    end else begin
      m_tready <= !(idle_ok && $urandom_range(99) < 7);
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("Mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    errors++;
  endtask

  // Monitor: every result beat against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report("unexpected beat, kind", m_tuser, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser != want.kind) report("result kind", m_tuser, want.kind);
        if (m_tdata[63:0] != want.x_bits) report("x bits", m_tdata[63:0], want.x_bits);
        if (m_tdata[127:64] != want.y_bits)
          report("y bits", m_tdata[127:64], want.y_bits);
        if (m_tdata[128] != want.line_start)
          report("line start", m_tdata[128], want.line_start);
        if (m_tdata[160:129] != want.points_parsed)
          report("points parsed", m_tdata[160:129], want.points_parsed);
        if (m_tlast != want.last) report("last result", m_tlast, want.last);
        case (want.kind)
          KIND_POINT:    n_points++;
          KIND_ACCEPTED: n_accepted++;
          default:       n_rejected++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  task automatic drain();
    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    int seen = cfg_writes;
    @(negedge clk);
    cfg_want = m;
    cfg_req = 1;
    while (cfg_writes == seen) @(posedge clk);
  endtask

  task automatic run_phase(bit m, int nbytes);
    int target = pending_bytes.size() + nbytes;
    @(negedge clk);
    while (pending_bytes.size() < target) queue_blob(m);
    drain();
  endtask

  task automatic short_blob(logic [7:0] bytes[$]);
    blob.delete();
    foreach (bytes[i]) put(bytes[i]);
    blob[blob.size() - 1].last = 1;
    foreach (blob[i]) pending_bytes.insert(pending_bytes.size(), blob[i]);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    set_mode(0);
    // Directed: a bad first letter, blobs ending inside or just after the
    // header, and a byte order byte out of range.
    @(negedge clk);
    short_blob('{8'h58});
    short_blob('{MAGIC_G, MAGIC_P});
    short_blob('{MAGIC_G, MAGIC_P, 8'h00, 8'h0E, 8'hFF, 8'h00, 8'hFF, 8'h00});
    short_blob('{MAGIC_G, MAGIC_P, 8'hFF, 8'hF1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h02});
    drain();
    run_phase(0, 650);
    set_mode(1);
    run_phase(1, 650);
    set_mode(0);
    run_phase(0, 320);
    set_mode(1);
    run_phase(1, 320);
    repeat (20) @(posedge clk);
    $display("Covered %0d blob bytes in both geometry modes: %0d points,", bytes_in, n_points);
    $display("%0d blobs accepted and %0d rejected.", n_accepted, n_rejected);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wkbpx_pkg.sv
rtl/wkbpx_parser.sv
rtl/wkbpx_out_fifo.sv
rtl/wkb_geometry_point_extractor_top.sv
tb/sv/tb_wkb_geometry_point_extractor_top.sv
